// ===== src/hid_pkg.sv =====
// Shared types, constants and field tables for the hardware-id time histogram.
package hid_pkg;

  localparam int NUM_FIELDS   = 11;
  localparam int TOTAL_IDS    = 474;
  localparam int SLOT_W       = 9;
  localparam int CNT_W        = 64;
  localparam int TS_W         = 64;
  localparam int DEF_MAX_BINS = 128;
  localparam int QDEPTH       = 2;

  localparam logic [7:0] BIN_COUNT_RST = 8'd100;

  localparam logic [1:0] CFG_START_TIME = 2'd0;
  localparam logic [1:0] CFG_END_TIME   = 2'd1;
  localparam logic [1:0] CFG_BIN_COUNT  = 2'd2;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_RDATA
  } back_state_t;

  typedef struct packed {
    logic              action;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [TS_W-1:0]   product;
    logic [6:0]        rbin;
  } hid_entry_t;

  function automatic logic [15:0] field_size(input logic [3:0] f);
    logic [15:0] s;
    unique case (f)
      4'd0:    s = 16'd64;
      4'd1:    s = 16'd16;
      4'd2:    s = 16'd4;
      4'd3:    s = 16'd128;
      4'd4:    s = 16'd16;
      4'd5:    s = 16'd128;
      4'd6:    s = 16'd32;
      4'd7:    s = 16'd2;
      4'd8:    s = 16'd64;
      4'd9:    s = 16'd16;
      4'd10:   s = 16'd4;
      default: s = 16'd0;
    endcase
    return s;
  endfunction

  function automatic logic [SLOT_W-1:0] field_base(input logic [3:0] f);
    logic [SLOT_W-1:0] b;
    unique case (f)
      4'd0:    b = 9'd0;
      4'd1:    b = 9'd64;
      4'd2:    b = 9'd80;
      4'd3:    b = 9'd84;
      4'd4:    b = 9'd212;
      4'd5:    b = 9'd228;
      4'd6:    b = 9'd356;
      4'd7:    b = 9'd388;
      4'd8:    b = 9'd390;
      4'd9:    b = 9'd454;
      4'd10:   b = 9'd470;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== src/hid_ram.sv =====
// Generic single-port RAM with registered read.
module hid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== src/hid_queue.sv =====
// Short entry queue between the front and back parts.
module hid_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hid_pkg::hid_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                nempty,
  output hid_pkg::hid_entry_t head
);
  import hid_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  hid_entry_t      slots [QDEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     fill;

  assign full   = (fill == (PW+1)'(QDEPTH));
  assign nempty = (fill != '0);
  assign head   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end
endmodule

// ===== src/hid_front.sv =====
// Front part: input transfer, item classification and bin product.
module hid_front #(
  parameter int MAX_BINS = hid_pkg::DEF_MAX_BINS,
  parameter int BCW      = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      hold,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic [3:0]                field_select,
  input  logic [15:0]               id_value,
  input  logic [hid_pkg::TS_W-1:0]  timestamp,
  input  logic [6:0]                read_bin,
  input  logic [hid_pkg::TS_W-1:0]  win_start,
  input  logic [BCW-1:0]            bins_m1,
  input  logic                      q_full,
  output logic                      q_push,
  output hid_pkg::hid_entry_t       q_data
);
  import hid_pkg::*;

  logic              s1_valid;
  logic              s1_action;
  logic              s1_ok;
  logic [SLOT_W-1:0] s1_slot;
  logic [TS_W-1:0]   s1_rel;
  logic [6:0]        s1_rbin;
  logic              fld_ok;
  logic              id_ok;
  logic              rbin_ok;
  logic              accept;

  assign q_push   = s1_valid && !q_full;
  assign in_ready = !hold && (!s1_valid || !q_full);
  assign accept   = in_valid && in_ready;

  assign fld_ok  = (32'(field_select) < NUM_FIELDS);
  assign id_ok   = (id_value < field_size(field_select));
  assign rbin_ok = (32'(read_bin) < MAX_BINS);

  always_comb begin
    q_data.action  = s1_action;
    q_data.ok      = s1_ok;
    q_data.slot    = s1_slot;
    q_data.product = TS_W'(s1_rel * TS_W'(bins_m1));
    q_data.rbin    = s1_rbin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action;
      s1_ok     <= fld_ok && id_ok && (action == ACT_RECORD || rbin_ok);
      s1_slot   <= field_base(field_select) + SLOT_W'(id_value);
      s1_rel    <= timestamp - win_start;
      s1_rbin   <= read_bin;
    end
  end
endmodule

// ===== src/hid_div.sv =====
// Restoring 64-bit divider, one quotient bit per cycle.
module hid_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [hid_pkg::TS_W-1:0] dividend,
  input  logic [hid_pkg::TS_W-1:0] divisor,
  output logic                     done,
  output logic [hid_pkg::TS_W-1:0] quotient
);
  import hid_pkg::*;

  localparam int CW = $clog2(TS_W);

  logic [TS_W:0]   rem;
  logic [TS_W:0]   rem_next;
  logic [TS_W:0]   shifted;
  logic [TS_W-1:0] quo_next;
  logic [TS_W-1:0] dvs;
  logic [CW-1:0]   cnt;
  logic            run;

  always_comb begin
    shifted = {rem[TS_W-1:0], quotient[TS_W-1]};
    if (shifted >= {1'b0, dvs}) begin
      rem_next = shifted - {1'b0, dvs};
      quo_next = {quotient[TS_W-2:0], 1'b1};
    end else begin
      rem_next = shifted;
      quo_next = {quotient[TS_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(TS_W-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (run) begin
      quotient <= quo_next;
      rem      <= rem_next;
    end
  end
endmodule

// ===== src/hid_back.sv =====
// Back part: clearing pass, bin division and counter read-modify-write.
module hid_back #(
  parameter int MAX_BINS = hid_pkg::DEF_MAX_BINS,
  parameter int BCW      = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_nempty,
  input  hid_pkg::hid_entry_t       q_head,
  output logic                      q_pop,
  input  logic [BCW-1:0]            eff_bins,
  input  logic [hid_pkg::TS_W-1:0]  range_nz,
  output logic                      clearing,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hid_pkg::CNT_W-1:0] count,
  output logic [6:0]                hist_bin,
  output logic                      in_range
);
  import hid_pkg::*;

  localparam int DEPTH = TOTAL_IDS * MAX_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  back_state_t     st;
  back_state_t     st_next;
  hid_entry_t      e;
  logic [IW-1:0]   bin_q;
  logic [IW-1:0]   bin_calc;
  logic [AW-1:0]   addr_q;
  logic [AW-1:0]   addr_calc;
  logic [AW-1:0]   clr_addr;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [CNT_W-1:0] ram_wdata;
  logic [CNT_W-1:0] ram_rdata;
  logic            div_start;
  logic            div_done;
  logic [TS_W-1:0] div_q;
  logic [31:0]     low;
  logic            rec_hit;

  assign low       = div_q[31:0];
  assign addr_calc = AW'(e.slot) * AW'(MAX_BINS) + AW'(bin_q);
  assign rec_hit   = e.ok && (e.action == ACT_RECORD);
  assign clearing  = (st == ST_CLEAR);

  always_comb begin
    if (low[31]) begin
      bin_calc = '0;
    end else if (low >= 32'(eff_bins)) begin
      bin_calc = IW'(eff_bins - 1'b1);
    end else begin
      bin_calc = IW'(low);
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_CLEAR: if (clr_addr == AW'(DEPTH-1)) st_next = ST_IDLE;
      ST_IDLE: begin
        if (q_nempty && !out_valid) begin
          st_next = (q_head.action == ACT_RECORD) ? ST_DIV : ST_ADDR;
        end
      end
      ST_DIV:   if (div_done) st_next = ST_ADDR;
      ST_ADDR:  st_next = ST_RDATA;
      ST_RDATA: st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (st == ST_IDLE) && q_nempty && !out_valid;
    div_start = q_pop && (q_head.action == ACT_RECORD);
    ram_we    = 1'b0;
    ram_wdata = ram_rdata + 1'b1;
    ram_addr  = addr_q;
    unique case (st)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ram_addr  = clr_addr;
      end
      ST_ADDR:  ram_addr = addr_calc;
      ST_RDATA: ram_we = rec_hit;
      default:  ram_addr = addr_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (st == ST_RDATA) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      e     <= q_head;
      bin_q <= IW'(q_head.rbin);
    end
    if (st == ST_DIV && div_done) begin
      bin_q <= bin_calc;
    end
    if (st == ST_ADDR) begin
      addr_q <= addr_calc;
    end
    if (st == ST_RDATA) begin
      in_range <= e.ok;
      hist_bin <= (e.action == ACT_RECORD) ? 7'(bin_q) : e.rbin;
      if (!e.ok) begin
        count <= '0;
      end else if (e.action == ACT_RECORD) begin
        count <= ram_rdata + 1'b1;
      end else begin
        count <= ram_rdata;
      end
    end
  end

  hid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q_head.product),
    .divisor  (range_nz),
    .done     (div_done),
    .quotient (div_q)
  );

  hid_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> count == '0)
    else $error("ignored item with nonzero count");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    st == ST_CLEAR |-> !out_valid && !q_pop)
    else $error("activity during clearing pass");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> st == ST_DIV)
    else $error("divider finished outside division state");

  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !out_valid)
    else $error("entry taken while result pending");
endmodule

// ===== src/hw_id_time_histogram_core.sv =====
// Top level of the hardware-id time-binned histogram.
//
//  channel | signals                                        | dir
//  in      | in_valid in_ready action field_select id_value |
//          | timestamp read_bin                             | in
//  out     | out_valid out_ready count hist_bin in_range    | out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data         | in
//
// Record item: the 64-step divider sets its bin before the counter update; read item: skips the divider.
// Counter RAM is one port: read-modify-write spends an address state and a data state.
// After reset a clearing pass zeroes all 474*MAX_BINS RAM words; in_ready is low.
// Two-entry queue lets the front take transfers while the back is busy.
// Result register frees the back only once out_ready takes the transfer.
module hw_id_time_histogram_core #(
  parameter int MAX_BINS = hid_pkg::DEF_MAX_BINS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic [3:0]                field_select,
  input  logic [15:0]               id_value,
  input  logic [hid_pkg::TS_W-1:0]  timestamp,
  input  logic [6:0]                read_bin,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hid_pkg::CNT_W-1:0] count,
  output logic [6:0]                hist_bin,
  output logic                      in_range,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [63:0]               cfg_data
);
  import hid_pkg::*;

  localparam int BW  = $clog2(MAX_BINS + 1);
  localparam int BCW = (BW > 8) ? BW : 8;

  logic [TS_W-1:0] win_start;
  logic [TS_W-1:0] win_end;
  logic [7:0]      bin_count;
  logic [BCW-1:0]  eff_bins;
  logic [TS_W-1:0] span;
  logic [TS_W-1:0] range_nz;
  logic            clearing;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_nempty;
  hid_entry_t      q_data;
  hid_entry_t      q_head;

  assign cfg_ready = 1'b1;
  assign span      = win_end - win_start;
  assign range_nz  = (span == '0) ? TS_W'(1) : span;

  always_comb begin
    if (bin_count == '0) begin
      eff_bins = BCW'(1);
    end else if (32'(bin_count) > MAX_BINS) begin
      eff_bins = BCW'(MAX_BINS);
    end else begin
      eff_bins = BCW'(bin_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_start <= '0;
      win_end   <= '0;
      bin_count <= BIN_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_TIME: win_start <= cfg_data;
        CFG_END_TIME:   win_end   <= cfg_data;
        CFG_BIN_COUNT:  bin_count <= cfg_data[7:0];
        default:        ;
      endcase
    end
  end

  hid_front #(
    .MAX_BINS (MAX_BINS),
    .BCW      (BCW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .hold         (clearing),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .field_select (field_select),
    .id_value     (id_value),
    .timestamp    (timestamp),
    .read_bin     (read_bin),
    .win_start    (win_start),
    .bins_m1      (eff_bins - 1'b1),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  hid_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .nempty    (q_nempty),
    .head      (q_head)
  );

  hid_back #(
    .MAX_BINS (MAX_BINS),
    .BCW      (BCW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_nempty  (q_nempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .eff_bins  (eff_bins),
    .range_nz  (range_nz),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .count     (count),
    .hist_bin  (hist_bin),
    .in_range  (in_range)
  );
endmodule
